// ===== rtl/core/sdft_pkg.sv =====
// Shared types, constants and helpers for the sliding DFT block.
// No dependencies; imported by the front end, the back end and the top level.

package sdft_pkg;

  localparam int DEF_WINDOW_LENGTH = 32;
  localparam int SAMPLE_W          = 16;
  localparam int DELTA_W           = 25;  // (new - old) * 256
  localparam int BIN_W             = 32;
  localparam int IDX_W             = 6;
  localparam int KIND_W            = 2;
  localparam int COEF_W            = 17;

  localparam logic REG_WINDOW_KIND = 1'b0;

  // Q1.15 window coefficients; kind 0 passes the bin through (a0 = 1.0)
  localparam logic signed [COEF_W-1:0] WIN_A0 [4] =
    '{17'sd32768, 17'sd16384, 17'sd17695, 17'sd13763};
  localparam logic signed [COEF_W-1:0] WIN_A1 [4] =
    '{17'sd0, -17'sd8192, -17'sd7537, -17'sd8192};
  localparam logic signed [COEF_W-1:0] WIN_A2 [4] =
    '{17'sd0, 17'sd0, 17'sd0, 17'sd1311};

  typedef struct packed {
    logic                      start;
    logic signed [DELTA_W-1:0] value;  // sample on start, else scaled delta
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic                    last;
  } result_t;

  typedef enum logic [1:0] {F_IDLE, F_READ, F_SEND} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_INIT, B_UPD_RD, B_UPD_MUL, B_UPD_WR,
    B_WIN_RD, B_WIN_SH, B_WIN_MUL, B_WIN_OUT
  } back_state_t;

  function automatic logic signed [BIN_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[BIN_W-1:0];
  endfunction

  // round half up, drop 15 fraction bits
  function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
    return (v + 64'sd16384) >>> 15;
  endfunction

endpackage

// ===== rtl/core/sdft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sdft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sdft_fifo.sv =====
// Two-word register queue used between the block's stages and at its output.
// No dependencies.

module sdft_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic [WIDTH-1:0] mem_nxt [2];
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;
  logic             wr_idx;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = mem_r[0];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign wr_idx  = 1'(count_r - {1'b0, do_pop});

  always_comb begin
    mem_nxt   = mem_r;
    count_nxt = count_r;
    if (do_pop) begin
      mem_nxt[0] = mem_r[1];
    end
    if (do_push) begin
      mem_nxt[wr_idx] = wdata;
    end
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    mem_r <= mem_nxt;
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/sdft_front.sv =====
// Front end: accepts samples, runs the delay line and forms the update job.
// Depends on sdft_pkg and sdft_ram.

module sdft_front import sdft_pkg::*; #(
  parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_start_trace,
  output logic                       full,
  output logic                       job_push,
  output job_t                       job_data,
  input  logic                       job_full
);

  localparam int HAW = $clog2(WINDOW_LENGTH);

  front_state_t              state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, base_r, old_smp, ram_q;
  logic                      start_r, wrapped_r;
  logic [HAW-1:0]            ptr_r;
  logic                      ram_we;
  logic signed [SAMPLE_W:0]  diff;
  logic                      ptr_last;

  sdft_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_LENGTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (sample_r),
    .raddr (ptr_r),
    .rdata (ram_q)
  );

  assign ptr_last = (ptr_r == HAW'(WINDOW_LENGTH - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (push) state_nxt = F_READ;
      F_READ: state_nxt = F_SEND;
      F_SEND: if (!job_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // entries not yet rewritten since the trace start still hold its sample
  always_comb begin
    full           = (state_r != F_IDLE);
    job_push       = (state_r == F_SEND) && !job_full;
    ram_we         = job_push && !start_r;
    old_smp        = wrapped_r ? ram_q : base_r;
    diff           = {sample_r[SAMPLE_W-1], sample_r} - {old_smp[SAMPLE_W-1], old_smp};
    job_data.start = start_r;
    job_data.value = start_r ? DELTA_W'(sample_r) : {diff, 8'b0};
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && push) begin
      sample_r <= in_sample;
      start_r  <= in_start_trace;
    end
    if (!rst_n) begin
      state_r   <= F_IDLE;
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      base_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (job_push) begin
        if (start_r) begin
          ptr_r     <= '0;
          wrapped_r <= 1'b0;
          base_r    <= sample_r;
        end else begin
          ptr_r <= ptr_last ? '0 : ptr_r + 1'b1;
          if (ptr_last) wrapped_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sdft_back.sv =====
// Back end: sliding update of the bin store and frequency-domain windowing.
// Depends on sdft_pkg and sdft_ram.

module sdft_back import sdft_pkg::*; #(
  parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              job_pop,
  input  job_t              job_data,
  input  logic              job_empty,
  input  logic [KIND_W-1:0] window_kind,
  output logic              res_push,
  output result_t           res_data,
  input  logic              res_full
);

  localparam int NBINS = WINDOW_LENGTH / 2 + 1;
  localparam int BAW   = $clog2(NBINS);
  localparam int JW    = BAW + 2;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI4_Q32 = 64'd3373259426;

  function automatic logic signed [15:0] satq15(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // cos in bits 15..0, sin in 31..16, Q1.15 (evaluated at elaboration)
  function automatic logic [31:0] make_twiddle(input int unsigned k);
    logic [63:0] eight, oct, rem, uval, x, x2, t, s15, c15;
    logic signed [63:0] cs, sn;
    eight = 64'(k) * 64'd8;
    oct   = eight / WINDOW_LENGTH;
    rem   = eight % WINDOW_LENGTH;
    uval  = oct[0] ? 64'(WINDOW_LENGTH) - rem : rem;
    x     = ((uval * PI4_Q32) / WINDOW_LENGTH + 64'd2) >> 2;
    x2    = (x * x) >> 30;
    t     = Q30_ONE - x2 / 72;
    t     = Q30_ONE - ((x2 * t) >> 30) / 42;
    t     = Q30_ONE - ((x2 * t) >> 30) / 20;
    t     = Q30_ONE - ((x2 * t) >> 30) / 6;
    s15   = (((x * t) >> 30) + 64'd16384) >> 15;
    t     = Q30_ONE - x2 / 90;
    t     = Q30_ONE - ((x2 * t) >> 30) / 56;
    t     = Q30_ONE - ((x2 * t) >> 30) / 30;
    t     = Q30_ONE - ((x2 * t) >> 30) / 12;
    t     = Q30_ONE - ((x2 * t) >> 30) / 2;
    c15   = (t + 64'd16384) >> 15;
    case (oct)
      64'd0:   begin cs = c15;  sn = s15;  end
      64'd1:   begin cs = s15;  sn = c15;  end
      64'd2:   begin cs = -s15; sn = c15;  end
      64'd3:   begin cs = -c15; sn = s15;  end
      default: begin cs = -c15; sn = -s15; end
    endcase
    return {satq15(sn), satq15(cs)};
  endfunction

  logic [31:0] tw_rom [NBINS];
  for (genvar g = 0; g < NBINS; g++) begin : g_tw
    assign tw_rom[g] = make_twiddle(g);
  end

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [BAW-1:0] k_r;
  logic signed [JW-1:0] j_r;
  logic [NBINS-1:0] valid_r;
  logic vq_r, conj_r;

  logic ram_we;
  logic [BAW-1:0] waddr, raddr;
  logic [63:0] wdata, ram_q;
  logic signed [BIN_W-1:0] rd_re, rd_im;

  logic signed [48:0] p_rc_r, p_is_r, p_rs_r, p_ic_r;
  logic signed [32:0] tap_re_r [5];
  logic signed [32:0] tap_im_r [5];
  logic signed [50:0] wp_re_r [3];
  logic signed [50:0] wp_im_r [3];

  logic signed [JW:0]    jx, mv;
  logic                  conj_now;
  logic signed [32:0]    tr, ti;
  logic signed [15:0]    tw_c, tw_s;
  logic signed [BIN_W-1:0] upd_re, upd_im, win_re, win_im, init_re;
  logic signed [COEF_W-1:0] a0, a1, a2;
  logic                  last_j, win_full;

  sdft_ram #(.WIDTH(64), .DEPTH(NBINS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // bins never written since reset or trace start read as zero
  assign rd_re = vq_r ? ram_q[31:0] : '0;
  assign rd_im = vq_r ? ram_q[63:32] : '0;

  // map a spectrum index to a stored bin using conjugate symmetry
  always_comb begin
    jx       = (JW + 1)'(j_r);
    conj_now = 1'b1;
    if (j_r < 0) begin
      mv = -jx;
    end else if (jx >= (JW + 1)'(NBINS)) begin
      mv = (JW + 1)'(WINDOW_LENGTH) - jx;
    end else begin
      mv       = jx;
      conj_now = 1'b0;
    end
  end

  always_comb begin
    tw_c    = tw_rom[k_r][15:0];
    tw_s    = tw_rom[k_r][31:16];
    tr      = 33'(rd_re) + 33'(job_r.value);
    ti      = 33'(rd_im);
    upd_re  = sat32(rnd15(64'(p_rc_r) - 64'(p_is_r)));
    upd_im  = sat32(rnd15(64'(p_rs_r) + 64'(p_ic_r)));
    win_re  = sat32(rnd15(64'(wp_re_r[0]) + 64'(wp_re_r[1]) + 64'(wp_re_r[2])));
    win_im  = sat32(rnd15(64'(wp_im_r[0]) + 64'(wp_im_r[1]) + 64'(wp_im_r[2])));
    init_re = sat32(64'(job_r.value) * 64'(WINDOW_LENGTH) * 64'sd256);
    a0      = WIN_A0[window_kind];
    a1      = WIN_A1[window_kind];
    a2      = WIN_A2[window_kind];
    last_j  = (j_r == JW'(NBINS + 1));
    win_full = (j_r >= JW'(2));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:    if (!job_empty) state_nxt = job_data.start ? B_INIT : B_UPD_RD;
      B_INIT:    state_nxt = B_WIN_RD;
      B_UPD_RD:  state_nxt = B_UPD_MUL;
      B_UPD_MUL: state_nxt = B_UPD_WR;
      B_UPD_WR:  state_nxt = (k_r == BAW'(NBINS - 1)) ? B_WIN_RD : B_UPD_RD;
      B_WIN_RD:  state_nxt = B_WIN_SH;
      B_WIN_SH:  state_nxt = win_full ? B_WIN_MUL : B_WIN_RD;
      B_WIN_MUL: state_nxt = B_WIN_OUT;
      B_WIN_OUT: if (!res_full) state_nxt = last_j ? B_IDLE : B_WIN_RD;
      default:   state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (state_r == B_IDLE) && !job_empty;
    ram_we   = 1'b0;
    waddr    = k_r;
    wdata    = {upd_im, upd_re};
    raddr    = k_r;
    res_push = (state_r == B_WIN_OUT) && !res_full;
    res_data.index = IDX_W'(j_r - JW'(2));
    res_data.re    = win_re;
    res_data.im    = win_im;
    res_data.last  = last_j;
    case (state_r)
      B_INIT: begin
        ram_we = 1'b1;
        waddr  = '0;
        wdata  = {32'sd0, init_re};
      end
      B_UPD_WR: ram_we = 1'b1;
      B_WIN_RD: raddr = BAW'(mv);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    vq_r <= valid_r[raddr];
    case (state_r)
      B_IDLE: begin
        job_r <= job_data;
        k_r   <= '0;
      end
      B_INIT: j_r <= -JW'(2);
      B_UPD_MUL: begin
        p_rc_r <= 49'(tr) * 49'(tw_c);
        p_is_r <= 49'(ti) * 49'(tw_s);
        p_rs_r <= 49'(tr) * 49'(tw_s);
        p_ic_r <= 49'(ti) * 49'(tw_c);
      end
      B_UPD_WR: begin
        k_r <= k_r + 1'b1;
        j_r <= -JW'(2);
      end
      B_WIN_RD: conj_r <= conj_now;
      B_WIN_SH: begin
        for (int i = 0; i < 4; i++) begin
          tap_re_r[i] <= tap_re_r[i+1];
          tap_im_r[i] <= tap_im_r[i+1];
        end
        tap_re_r[4] <= 33'(rd_re);
        tap_im_r[4] <= conj_r ? -33'(rd_im) : 33'(rd_im);
        if (!win_full) j_r <= j_r + 1'b1;
      end
      B_WIN_MUL: begin
        wp_re_r[0] <= 51'(a0) * 51'(tap_re_r[2]);
        wp_re_r[1] <= 51'(a1) * 51'(34'(tap_re_r[1]) + 34'(tap_re_r[3]));
        wp_re_r[2] <= 51'(a2) * 51'(34'(tap_re_r[0]) + 34'(tap_re_r[4]));
        wp_im_r[0] <= 51'(a0) * 51'(tap_im_r[2]);
        wp_im_r[1] <= 51'(a1) * 51'(34'(tap_im_r[1]) + 34'(tap_im_r[3]));
        wp_im_r[2] <= 51'(a2) * 51'(34'(tap_im_r[0]) + 34'(tap_im_r[4]));
      end
      B_WIN_OUT: if (!res_full) j_r <= j_r + 1'b1;
      default: ;
    endcase
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_INIT) begin
        valid_r <= NBINS'(1);
      end else if (state_r == B_UPD_WR) begin
        valid_r[k_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sliding_dft_freq_window.sv =====
// Top level of the sliding DFT with frequency-domain window.
// Depends on sdft_pkg, sdft_fifo, sdft_front and sdft_back.

// Each sample produces WINDOW_LENGTH/2+1 result words (bins 0 upward, last_bin on the
// final one). A start_trace sample skips the update pass. The back end runs every bin
// through one complex multiplier (read, multiply, write back) and then through the
// window unit (read, shift into the taps, multiply, output), one bin store read per
// step; the taps are filled before the first bin goes out. The front end reads the
// delay line while the back end works, so the next sample waits only in the two-word
// job queue.
// window_kind (byte address 0) must be written only while the block is idle.

module sliding_dft_freq_window import sdft_pkg::*; #(
  parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_start_trace,
  output logic                       full,
  output logic                       empty,
  input  logic                       pop,
  output logic [IDX_W-1:0]           out_bin_index,
  output logic signed [BIN_W-1:0]    out_bin_real,
  output logic signed [BIN_W-1:0]    out_bin_imag,
  output logic                       out_last_bin,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [KIND_W-1:0] kind_r;
  logic    job_push, job_full, job_pop, job_empty;
  job_t    job_in, job_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_KIND) ? {30'b0, kind_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_KIND) begin
      kind_r <= pwdata[KIND_W-1:0];
    end
  end

  sdft_front #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_sample      (in_sample),
    .in_start_trace (in_start_trace),
    .full           (full),
    .job_push       (job_push),
    .job_data       (job_in),
    .job_full       (job_full)
  );

  sdft_fifo #(.WIDTH($bits(job_t))) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  sdft_back #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_pop     (job_pop),
    .job_data    (job_out),
    .job_empty   (job_empty),
    .window_kind (kind_r),
    .res_push    (res_push),
    .res_data    (res_in),
    .res_full    (res_full)
  );

  sdft_fifo #(.WIDTH($bits(result_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_bin_index = res_out.index;
  assign out_bin_real  = res_out.re;
  assign out_bin_imag  = res_out.im;
  assign out_last_bin  = res_out.last;

endmodule
